/* hdl/mva_pkg.sv */
// ----------------------------------------------------------------------------
// mva_pkg
// Shared constants and the pitch table of the MIDI voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam logic [25:0] STEP_K = 26'd26266401;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;
  localparam logic [3:0] PERC_CHANNEL  = 4'h9;
  localparam logic [6:0] CC_PEDAL      = 7'h40;
  localparam logic [6:0] CC_VOLUME     = 7'h07;
  localparam logic [6:0] CC_ALL_OFF    = 7'h78;
  localparam logic [6:0] CC_RESET_ALL  = 7'h79;
  localparam logic [6:0] BEND_CENTER   = 7'h40;
  localparam logic [6:0] PEDAL_LIMIT   = 7'd50;
  localparam logic [6:0] KEY_OFFSET    = 7'd11;
  localparam logic [7:0] NO_CHANNEL    = 8'd255;
  localparam logic [7:0] NO_KEY        = 8'd255;
  localparam logic [7:0] GAIN_RESET    = 8'd128;

  localparam logic [15:0] FREQ_TAB [128] = '{
    16'd16, 16'd17, 16'd18, 16'd19, 16'd21, 16'd22, 16'd23, 16'd24, 16'd26,
    16'd28, 16'd29, 16'd31, 16'd33, 16'd35, 16'd37, 16'd39, 16'd41, 16'd44,
    16'd46, 16'd49, 16'd52, 16'd55, 16'd58, 16'd62, 16'd65, 16'd69, 16'd73,
    16'd78, 16'd82, 16'd87, 16'd92, 16'd98, 16'd104, 16'd110, 16'd117,
    16'd123, 16'd131, 16'd139, 16'd147, 16'd156, 16'd165, 16'd175, 16'd185,
    16'd196, 16'd208, 16'd220, 16'd233, 16'd247, 16'd262, 16'd277, 16'd294,
    16'd311, 16'd330, 16'd349, 16'd370, 16'd392, 16'd415, 16'd440, 16'd466,
    16'd494, 16'd523, 16'd554, 16'd587, 16'd622, 16'd659, 16'd698, 16'd740,
    16'd784, 16'd831, 16'd880, 16'd932, 16'd988, 16'd1047, 16'd1109,
    16'd1175, 16'd1245, 16'd1319, 16'd1397, 16'd1480, 16'd1568, 16'd1661,
    16'd1760, 16'd1865, 16'd1976, 16'd2093, 16'd2217, 16'd2349, 16'd2489,
    16'd2637, 16'd2794, 16'd2960, 16'd3136, 16'd3322, 16'd3520, 16'd3729,
    16'd3951, 16'd4186, 16'd4435, 16'd4699, 16'd4978, 16'd5274, 16'd5588,
    16'd5920, 16'd6272, 16'd6645, 16'd7040, 16'd7459, 16'd7902, 16'd8372,
    16'd8870, 16'd9397, 16'd9956, 16'd10548, 16'd11175, 16'd11840,
    16'd12544, 16'd13290, 16'd14080, 16'd14917, 16'd15804, 16'd16744,
    16'd17740, 16'd18795, 16'd19912, 16'd21096, 16'd22351, 16'd23680,
    16'd25088
  };

  function automatic logic [15:0] tab(input logic [8:0] i);
    return (i > 9'd127) ? FREQ_TAB[127] : FREQ_TAB[i[6:0]];
  endfunction

endpackage

/* hdl/midi_voice_allocator_unit.sv */
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit
// Polyphonic voice allocator: handles MIDI messages and audio ticks.
// ----------------------------------------------------------------------------
// A tick walks every voice through S_TICK and S_OUT, waiting in S_OUT while the output stalls; one result a voice.
// A message walks all voices once per pass.
// A phase step is the product hz * STEP_K, formed in S_STEP_A or S_BEND_A and stored in S_STEP_B or S_BEND_B.
// Reset is synchronous; all voice state returns to its reset value at once.
// The block is not ready while an item is in work.
module midi_voice_allocator_unit #(
  parameter int VOICES = 12,
  parameter int PHASE_FRACTION_BITS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // status[7:0], key[14:8], amount[21:15], zero pad
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // voice[3:0], sounding[4], sample_index[20:5],
                                     // gain[28:21], zero pad
  output logic        m_axis_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mva_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_OUT, S_MSG, S_FIND_KEY, S_FIND_FREE, S_STEP_A, S_STEP_B,
    S_BEND_A, S_BEND_B, S_DONE
  } state_t;

  state_t state;
  logic [VW-1:0] idx;
  logic [15:0] sample_length;
  logic hold_switch, pedal_on;
  logic [VOICES-1:0] voice_busy;
  logic [7:0] held_key [VOICES];
  logic [7:0] voice_channel [VOICES];
  logic [7:0] pitch_index [VOICES];
  logic [31:0] phase [VOICES];
  logic [15:0] phase_step [VOICES];
  logic [7:0] voice_gain [VOICES];
  logic [7:0] st;
  logic [6:0] key, amt;
  logic [31:0] best;
  logic [VW-1:0] pick, target;
  logic note_off_done;
  logic [15:0] hz;
  logic [41:0] prod;

  logic [3:0] kind;
  logic [7:0] ch8, n8;
  logic [31:0] end_ph, t_next;
  logic in_sample;
  logic [15:0] lo, hi, diff;
  logic [22:0] bend_mul;
  logic is_off;

  assign kind = st[7:4];
  assign ch8 = {4'h0, st[3:0]};
  assign n8 = {1'b0, key - KEY_OFFSET};
  assign end_ph = 32'({16'h0, sample_length} << PHASE_FRACTION_BITS);
  assign t_next = phase[idx] + {16'h0, phase_step[idx]};
  assign in_sample = (t_next >> PHASE_FRACTION_BITS) < {16'h0, sample_length};
  assign lo = tab((pitch_index[idx] >= 8'd2) ? {1'b0, pitch_index[idx] - 8'd2} : 9'd0);
  assign hi = tab({1'b0, pitch_index[idx]} + 9'd2);
  assign diff = (hi >= lo) ? hi - lo : 16'd0;
  assign bend_mul = 23'(diff * amt);
  assign is_off = !hold_switch && !pedal_on && st != {KIND_NOTE_OFF, PERC_CHANNEL}
                  && key >= KEY_OFFSET
                  && (kind == KIND_NOTE_OFF || (kind == KIND_NOTE_ON && amt == 7'd0));
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      sample_length <= 16'd1;
      hold_switch <= 1'b0;
      pedal_on <= 1'b0;
      voice_busy <= '0;
      m_axis_tvalid <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        held_key[v] <= 8'd0;
        voice_channel[v] <= NO_CHANNEL;
        pitch_index[v] <= 8'd0;
        phase[v] <= 32'd0;
        phase_step[v] <= 16'd0;
        voice_gain[v] <= GAIN_RESET;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == 1'b0) sample_length <= cfg_data;
        else hold_switch <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            st <= s_axis_tdata[7:0];
            key <= s_axis_tdata[14:8];
            amt <= s_axis_tdata[21:15];
            idx <= '0;
            state <= s_axis_tuser ? S_TICK : S_MSG;
          end
        end
        S_TICK: begin
          if (in_sample) begin
            phase[idx] <= t_next;
          end else if (voice_busy[idx]) begin
            voice_busy[idx] <= 1'b0;
            held_key[idx] <= NO_KEY;
            voice_channel[idx] <= NO_CHANNEL;
          end
          m_axis_tdata <= {3'd0, in_sample ? voice_gain[idx] : 8'd0,
                           in_sample ? t_next[PHASE_FRACTION_BITS +: 16] : 16'd0,
                           in_sample, 4'(idx)};
          m_axis_tlast <= (32'(idx) == VOICES - 1);
          m_axis_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (32'(idx) == VOICES - 1) state <= S_IDLE;
            else begin
              idx <= idx + 1'b1;
              state <= S_TICK;
            end
          end
        end
        S_MSG: begin
          // One pass over the voices for bend, controllers and note-off.
          if (kind == KIND_BEND && st != {KIND_BEND, PERC_CHANNEL}
              && voice_channel[idx] == ch8 && pitch_index[idx] != 8'd0) begin
            hz <= (amt == BEND_CENTER) ? tab({1'b0, pitch_index[idx]})
                  : 16'(bend_mul >> 7) + lo;
            target <= idx;
            state <= S_BEND_A;
          end else begin
            if (kind == KIND_CTRL && st != {KIND_CTRL, PERC_CHANNEL}) begin
              if (key == CC_PEDAL) pedal_on <= (amt > PEDAL_LIMIT);
              if (key == CC_VOLUME && voice_channel[idx] == ch8)
                voice_gain[idx] <= {1'b0, amt};
              if (key == CC_ALL_OFF && voice_channel[idx] == ch8) begin
                voice_channel[idx] <= NO_CHANNEL;
                phase[idx] <= end_ph;
                voice_busy[idx] <= 1'b0;
                pitch_index[idx] <= 8'd0;
              end
              if (key == CC_RESET_ALL) begin
                voice_channel[idx] <= NO_CHANNEL;
                voice_gain[idx] <= GAIN_RESET;
                pedal_on <= 1'b0;
              end
            end
            if (is_off && held_key[idx] == n8 && (idx == '0 || !note_off_done)) begin
              phase[idx] <= end_ph;
              voice_busy[idx] <= 1'b0;
              voice_channel[idx] <= NO_CHANNEL;
              held_key[idx] <= NO_KEY;
              note_off_done <= 1'b1;
            end else if (is_off && idx == '0) note_off_done <= 1'b0;
            if (32'(idx) == VOICES - 1) begin
              idx <= '0;
              state <= (kind == KIND_NOTE_ON && amt != 7'd0
                        && st != {KIND_NOTE_ON, PERC_CHANNEL} && key >= KEY_OFFSET)
                       ? S_FIND_KEY : S_DONE;
            end else idx <= idx + 1'b1;
          end
        end
        S_BEND_A: begin
          prod <= 42'(hz * STEP_K);
          state <= S_BEND_B;
        end
        S_BEND_B: begin
          phase_step[target] <= prod[39:24];
          if (32'(idx) == VOICES - 1) begin
            idx <= '0;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_MSG;
          end
        end
        S_FIND_KEY: begin
          if (held_key[idx] == n8) begin
            target <= idx;
            hz <= tab({1'b0, n8});
            state <= S_STEP_A;
          end else if (32'(idx) == VOICES - 1) begin
            idx <= '0;
            best <= 32'd0;
            pick <= '0;
            state <= S_FIND_FREE;
          end else idx <= idx + 1'b1;
        end
        S_FIND_FREE: begin
          if (!voice_busy[idx]) begin
            target <= idx;
            held_key[idx] <= n8;
            hz <= tab({1'b0, n8});
            state <= S_STEP_A;
          end else begin
            if (phase[idx] > best) begin
              best <= phase[idx];
              pick <= idx;
            end
            if (32'(idx) == VOICES - 1) begin
              target <= (phase[idx] > best) ? idx : pick;
              held_key[(phase[idx] > best) ? idx : pick] <= n8;
              hz <= tab({1'b0, n8});
              state <= S_STEP_A;
            end else idx <= idx + 1'b1;
          end
        end
        S_STEP_A: begin
          prod <= 42'(hz * STEP_K);
          state <= S_STEP_B;
        end
        S_STEP_B: begin
          voice_channel[target] <= ch8;
          pitch_index[target] <= n8;
          phase[target] <= 32'd0;
          phase_step[target] <= prod[39:24];
          voice_busy[target] <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_OUT) else $error("result outside output state");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> 32'(idx) == VOICES - 1) else $error("bad last");
`endif

endmodule
